>>> hdl/wmd_pkg.sv
// Shared types and constants for the wire message deframer.
// No dependencies; used by every module of the block.
package wmd_pkg;

  // Code of one result word.
  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindBody   = 2'd1,
    KindError  = 2'd2
  } kind_e;

  localparam logic [15:0] HeaderLen    = 16'd8;
  localparam logic [15:0] MaxSizeReset = 16'hFFFF;
  localparam int          QueueDepth   = 4;

  // Word handed from the front end to the result queue.
  typedef struct packed {
    logic  push;
    kind_e kind;
  } qword_t;

endpackage

>>> hdl/wmd_front.sv
// Front end: takes stream bytes, tracks header and body position, checks sizes.
// Depends on wmd_pkg.
module wmd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  output wmd_pkg::qword_t q_o
);

  logic [15:0] max_size_q;
  logic [15:0] pos_q, pos_d;
  logic [15:0] size_q, size_d;
  logic [7:0]  hdr_lo_q, hdr_lo_d;
  logic        in_body_q, in_body_d;
  logic        failed_q, failed_d;
  logic [15:0] new_size;
  logic [15:0] pos_inc;
  logic        size_bad;

  assign new_size = {data_byte_i, hdr_lo_q};
  assign pos_inc  = pos_q + 16'd1;
  assign size_bad = (new_size < wmd_pkg::HeaderLen) || (new_size > max_size_q) ||
                    (new_size[1:0] != 2'b00);

  always_comb begin
    pos_d       = pos_q;
    size_d      = size_q;
    hdr_lo_d    = hdr_lo_q;
    in_body_d   = in_body_q;
    failed_d    = failed_q;
    q_o.push    = 1'b0;
    q_o.kind    = wmd_pkg::KindBody;
    if (accept_i && !failed_q) begin
      if (in_body_q) begin
        q_o.push = 1'b1;
        if (pos_inc >= size_q) begin
          in_body_d = 1'b0;
          pos_d     = '0;
        end else begin
          pos_d = pos_inc;
        end
      end else if (pos_q < (wmd_pkg::HeaderLen - 16'd1)) begin
        // Only header byte 6, the low size byte, is needed later.
        if (pos_q == (wmd_pkg::HeaderLen - 16'd2)) begin
          hdr_lo_d = data_byte_i;
        end
        pos_d = pos_inc;
      end else begin
        q_o.push = 1'b1;
        if (size_bad) begin
          failed_d = 1'b1;
          q_o.kind = wmd_pkg::KindError;
        end else begin
          q_o.kind = wmd_pkg::KindHeader;
          size_d   = new_size;
          hdr_lo_d = '0;
          if (new_size == wmd_pkg::HeaderLen) begin
            pos_d     = '0;
            in_body_d = 1'b0;
          end else begin
            pos_d     = wmd_pkg::HeaderLen;
            in_body_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= wmd_pkg::MaxSizeReset;
      pos_q      <= '0;
      size_q     <= '0;
      hdr_lo_q   <= '0;
      in_body_q  <= 1'b0;
      failed_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
      pos_q     <= pos_d;
      size_q    <= size_d;
      hdr_lo_q  <= hdr_lo_d;
      in_body_q <= in_body_d;
      failed_q  <= failed_d;
    end
  end

endmodule

>>> hdl/wmd_queue.sv
// Back end: a short result queue that decouples the front end from the reader.
// Depends on wmd_pkg.
module wmd_queue #(
  parameter int Depth = wmd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wmd_pkg::qword_t q_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output wmd_pkg::kind_e  kind_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wmd_pkg::kind_e  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign kind_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (q_i.push) begin
      mem_q[wr_ptr_q] <= q_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (q_i.push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (q_i.push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!q_i.push && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> hdl/wire_message_deframer_top.sv
// Channel   Direction  Handshake        Payload
// input     in         push / full      data_byte_i   (8 bits)
// result    out        empty / pop      result_kind_o (2 bits)
// config    in         cfg_we_i         cfg_wdata_i   (16 bits, max message size)
//
// One byte is taken per cycle while full is low; a result word that it yields
// enters the queue at that edge and can be popped in the next cycle. full is
// high while the result queue holds QueueDepth unread words; a pop in that
// cycle frees a place only from the next cycle on.
// Reset is asynchronous, active low, and clears all control state.
// Depends on wmd_pkg, wmd_front and wmd_queue.
module wire_message_deframer_top #(
  parameter int QueueDepth = wmd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  wmd_pkg::qword_t qword;
  wmd_pkg::kind_e  kind;
  logic            accept;

  assign accept        = push && !full;
  assign result_kind_o = kind;

  wmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_o         (qword)
  );

  wmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_i     (qword),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .kind_o  (kind)
  );

endmodule
